// ===== rtl/c8ic_pkg.sv =====
// shared types, constants and the bcd helper function of the instruction core
package c8ic_pkg;

	localparam int unsigned STACK_DEPTH = 16;
	localparam int unsigned SP_W        = $clog2(STACK_DEPTH);

	localparam logic [11:0] PROG_START = 12'h200;
	localparam logic [11:0] FONT_BASE  = 12'h050;
	localparam int unsigned FONT_LEN   = 80;

	localparam logic [1:0] MODE_EXEC = 2'd0;
	localparam logic [1:0] MODE_LOAD = 2'd1;
	localparam logic [1:0] MODE_ROW  = 2'd2;
	// unused mode, only reports the program counter
	localparam logic [1:0] MODE_NOP  = 2'd3;

	// opcode groups (top nibble)
	localparam logic [3:0] GRP_SYS  = 4'h0;
	localparam logic [3:0] GRP_JP   = 4'h1;
	localparam logic [3:0] GRP_CALL = 4'h2;
	localparam logic [3:0] GRP_SEQ  = 4'h3;
	localparam logic [3:0] GRP_SNE  = 4'h4;
	localparam logic [3:0] GRP_SREQ = 4'h5;
	localparam logic [3:0] GRP_LDI  = 4'h6;
	localparam logic [3:0] GRP_ADDI = 4'h7;
	localparam logic [3:0] GRP_ALU  = 4'h8;
	localparam logic [3:0] GRP_SRNE = 4'h9;
	localparam logic [3:0] GRP_LDIX = 4'hA;
	localparam logic [3:0] GRP_JPV  = 4'hB;
	localparam logic [3:0] GRP_RND  = 4'hC;
	localparam logic [3:0] GRP_DRW  = 4'hD;
	localparam logic [3:0] GRP_KEY  = 4'hE;
	localparam logic [3:0] GRP_MISC = 4'hF;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	localparam logic [7:0] KEY_DOWN = 8'h9E;
	localparam logic [7:0] KEY_UP   = 8'hA1;

	localparam logic [7:0] FN_GDLY = 8'h07;
	localparam logic [7:0] FN_WKEY = 8'h0A;
	localparam logic [7:0] FN_SDLY = 8'h15;
	localparam logic [7:0] FN_SSND = 8'h18;
	localparam logic [7:0] FN_ADDI = 8'h1E;
	localparam logic [7:0] FN_FONT = 8'h29;
	localparam logic [7:0] FN_BCD  = 8'h33;
	localparam logic [7:0] FN_STOR = 8'h55;
	localparam logic [7:0] FN_LOAD = 8'h65;

	// low nibble of the 8xyN group
	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	localparam logic [3:0] REG_VF = 4'hF;

	typedef struct packed {
		logic [7:0] res;
		logic       flag;
		logic       wr_flag;
		logic       bad;
	} alu_res_t;

	localparam logic [7:0] FONT [FONT_LEN] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	// double dabble, hundreds in [11:8]
	function automatic logic [11:0] to_bcd(input logic [7:0] v);
		logic [19:0] s;
		s = {12'd0, v};
		for (int i = 0; i < 8; i++) begin
			if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
			if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
			s = s << 1;
		end
		return s[19:8];
	endfunction

endpackage

// ===== rtl/c8ic_alu.sv =====
// register-to-register arithmetic of the 8xyN group
module c8ic_alu
	import c8ic_pkg::*;
(
	input  logic [7:0] a,
	input  logic [7:0] b,
	input  logic [3:0] fn,
	output alu_res_t   r
);

	logic [8:0] sum;

	assign sum = {1'b0, a} + {1'b0, b};

	always_comb begin
		r = '0;
		case (fn)
			ALU_MOV: r.res = b;
			ALU_OR:  r.res = a | b;
			ALU_AND: r.res = a & b;
			ALU_XOR: r.res = a ^ b;
			ALU_ADD: begin
				r.res = sum[7:0]; r.flag = sum[8]; r.wr_flag = 1'b1;
			end
			ALU_SUB: begin
				r.res = a - b; r.flag = (a >= b); r.wr_flag = 1'b1;
			end
			ALU_SHR: begin
				r.res = a >> 1; r.flag = a[0]; r.wr_flag = 1'b1;
			end
			ALU_SBN: begin
				r.res = b - a; r.flag = (b >= a); r.wr_flag = 1'b1;
			end
			ALU_SHL: begin
				r.res = a << 1; r.flag = a[7]; r.wr_flag = 1'b1;
			end
			default: r.bad = 1'b1;
		endcase
	end

endmodule

// ===== rtl/chip8_instruction_core_top.sv =====
// instruction core top level: sequencer, memories and stream ports
// modes 1 and 3 go straight to the finishing state, mode 2 reads one frame buffer row;
//   mode 0 fetches, decodes and reads registers, then adds a flag write, a draw of height n,
//   a block store/load or bcd where the opcode needs it; the result then waits on m_tready
// throughput: one transaction at a time; every memory has one port per direction
// reset: arst_n clears control state at once, then a clearing pass over all of main memory
//   writes the font and zeros into it; no input is taken during it
module chip8_instruction_core_top
	import c8ic_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// load_address, load_byte, display_row, keys, random_value, delay_now, zero fill
	input  logic [63:0] s_tdata,
	// mode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// program_counter, row_pixels, drew, unknown_opcode, waiting_for_key,
	// delay_load, sound_load, timer_value, zero fill
	output logic [95:0] m_tdata
);

	typedef enum logic [21:0] {
		ST_CLR  = 22'd1 << 0,
		ST_IDLE = 22'd1 << 1,
		ST_F1   = 22'd1 << 2,
		ST_F2   = 22'd1 << 3,
		ST_DEC  = 22'd1 << 4,
		ST_RX   = 22'd1 << 5,
		ST_RY   = 22'd1 << 6,
		ST_R0   = 22'd1 << 7,
		ST_EXEC = 22'd1 << 8,
		ST_WRF  = 22'd1 << 9,
		ST_DRD  = 22'd1 << 10,
		ST_DWR  = 22'd1 << 11,
		ST_DEND = 22'd1 << 12,
		ST_B0   = 22'd1 << 13,
		ST_B1   = 22'd1 << 14,
		ST_B2   = 22'd1 << 15,
		ST_SRD  = 22'd1 << 16,
		ST_SWR  = 22'd1 << 17,
		ST_LRD  = 22'd1 << 18,
		ST_LWR  = 22'd1 << 19,
		ST_ROW  = 22'd1 << 20,
		ST_FIN  = 22'd1 << 21
	} state_t;

	state_t state_q;

	// input fields
	logic [1:0]  in_mode;
	logic [11:0] in_addr;
	logic [7:0]  in_byte;
	logic [4:0]  in_row;
	logic        accept;

	assign in_mode = s_tuser[1:0];
	assign in_addr = s_tdata[11:0];
	assign in_byte = s_tdata[19:12];
	assign in_row  = s_tdata[24:20];
	assign accept  = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	// architectural and working registers
	logic [11:0]     clr_q, pc_q, i_q;
	logic [SP_W-1:0] sp_q, sp_dec, sp_inc;
	logic [15:0]     op_q;
	logic [7:0]      ophi_q, vx_q, vy_q, v0_q;
	logic [15:0]     keys_q;
	logic [7:0]      rnd_q, dnow_q;
	logic [3:0]      r_q, j_q;
	logic            hit_q, flag_q;

	// result fields collected during the step
	logic [63:0] row_q;
	logic        drew_q, unk_q, wait_q, dl_q, sl_q;
	logic [7:0]  tval_q;
	logic [95:0] out_q;
	logic        out_vld_q;

	// opcode fields
	logic [3:0]  grp, x, y, n;
	logic [7:0]  nn;
	logic [11:0] nnn;

	assign grp = op_q[15:12];
	assign x   = op_q[11:8];
	assign y   = op_q[7:4];
	assign n   = op_q[3:0];
	assign nn  = op_q[7:0];
	assign nnn = op_q[11:0];

	// main memory: 4096 x 8, cleared and font-loaded after reset
	logic [7:0]  mem_ram [4096];
	logic [7:0]  mem_rd_q, mem_wdata;
	logic [11:0] mem_raddr, mem_waddr;
	logic        mem_we;

	always_ff @(posedge clk) begin
		if (mem_we) mem_ram[mem_waddr] <= mem_wdata;
		mem_rd_q <= mem_ram[mem_raddr];
	end

	// general registers: 16 x 8, valid bits stand for the zero reset
	logic [7:0]  v_ram [16];
	logic [7:0]  v_raw_q, v_rd, v_wdata;
	logic [3:0]  v_raddr, v_waddr;
	logic [15:0] v_vld_q;
	logic        v_rvld_q, v_we;

	always_ff @(posedge clk) begin
		if (v_we) v_ram[v_waddr] <= v_wdata;
		v_raw_q <= v_ram[v_raddr];
	end

	assign v_rd = v_rvld_q ? v_raw_q : 8'd0;

	// frame buffer: 32 rows of 64 pixels, valid bits clear all rows at once
	logic [63:0] fb_ram [32];
	logic [63:0] fb_raw_q, fb_rd, fb_wdata;
	logic [4:0]  fb_raddr, draw_row;
	logic [31:0] fb_vld_q;
	logic        fb_rvld_q, fb_we, fb_clear;

	always_ff @(posedge clk) begin
		if (fb_we) fb_ram[draw_row] <= fb_wdata;
		fb_raw_q <= fb_ram[fb_raddr];
	end

	assign fb_rd = fb_rvld_q ? fb_raw_q : 64'd0;

	// return stack
	logic [11:0]            stk_ram [STACK_DEPTH];
	logic [11:0]            stk_raw_q, stk_rd;
	logic [STACK_DEPTH-1:0] stk_vld_q;
	logic                   stk_rvld_q, stk_we;

	always_ff @(posedge clk) begin
		if (stk_we) stk_ram[sp_q] <= pc_q;
		stk_raw_q <= stk_ram[sp_dec];
	end

	assign stk_rd = stk_rvld_q ? stk_raw_q : 12'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_vld_q    <= '0;
			v_rvld_q   <= 1'b0;
			fb_vld_q   <= '0;
			fb_rvld_q  <= 1'b0;
			stk_vld_q  <= '0;
			stk_rvld_q <= 1'b0;
		end else begin
			v_rvld_q   <= v_vld_q[v_raddr];
			fb_rvld_q  <= fb_vld_q[fb_raddr];
			stk_rvld_q <= stk_vld_q[sp_dec];
			if (v_we) v_vld_q[v_waddr] <= 1'b1;
			if (fb_clear) fb_vld_q <= '0;
			else if (fb_we) fb_vld_q[draw_row] <= 1'b1;
			if (stk_we) stk_vld_q[sp_q] <= 1'b1;
		end
	end

	// stack pointer wraps modulo the stack depth
	assign sp_dec = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - 1'b1;
	assign sp_inc = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;

	// 8xyN arithmetic
	alu_res_t alu;

	c8ic_alu u_alu (
		.a  (vx_q),
		.b  (vy_q),
		.fn (n),
		.r  (alu)
	);

	// key lookups
	logic       key_hit;
	logic [3:0] low_key;

	assign key_hit = keys_q[vx_q[3:0]];

	always_comb begin
		low_key = 4'd0;
		for (int k = 15; k >= 0; k--)
			if (keys_q[k]) low_key = 4'(k);
	end

	// sprite row rotated to the x position, wrapping at the right edge
	logic [63:0]  spr64;
	logic [127:0] spr_rot;
	logic [63:0]  draw_mask;

	assign spr64     = {mem_rd_q, 56'd0};
	assign spr_rot   = {spr64, spr64} >> vx_q[5:0];
	assign draw_mask = spr_rot[63:0];
	assign draw_row  = vy_q[4:0] + {1'b0, r_q};
	assign fb_wdata  = fb_rd ^ draw_mask;

	logic [11:0] bcd;
	assign bcd = to_bcd(vx_q);

	// font image for the clearing pass
	logic        font_hit;
	logic [11:0] font_off;

	assign font_off = clr_q - FONT_BASE;
	assign font_hit = (clr_q >= FONT_BASE) && (clr_q < FONT_BASE + 12'(FONT_LEN));

	// next program counter and opcode legality
	logic [11:0] next_pc;
	logic        skip, unk_now;

	always_comb begin
		next_pc = pc_q + 12'd2;
		skip    = 1'b0;
		unk_now = 1'b0;
		case (grp)
			GRP_SYS: begin
				if (op_q == OP_RET) next_pc = stk_rd + 12'd2;
				else if (op_q != OP_CLS) unk_now = 1'b1;
			end
			GRP_JP, GRP_CALL: next_pc = nnn;
			GRP_SEQ:  skip = (vx_q == nn);
			GRP_SNE:  skip = (vx_q != nn);
			GRP_SREQ: skip = (vx_q == vy_q);
			GRP_SRNE: skip = (vx_q != vy_q);
			GRP_ALU:  unk_now = alu.bad;
			GRP_JPV:  next_pc = nnn + {4'd0, v0_q};
			GRP_KEY: begin
				if (nn == KEY_DOWN) skip = key_hit;
				else if (nn == KEY_UP) skip = !key_hit;
				else unk_now = 1'b1;
			end
			GRP_MISC: begin
				case (nn)
					FN_WKEY: if (keys_q == 16'd0) next_pc = pc_q;
					FN_GDLY, FN_SDLY, FN_SSND, FN_ADDI, FN_FONT,
					FN_BCD, FN_STOR, FN_LOAD: ;
					default: unk_now = 1'b1;
				endcase
			end
			default: ;
		endcase
		if (skip) next_pc = pc_q + 12'd4;
	end

	// memory ports by sequencer state
	always_comb begin
		mem_raddr = pc_q;
		v_raddr   = x;
		fb_raddr  = draw_row;
		mem_we    = 1'b0;
		mem_waddr = i_q;
		mem_wdata = 8'd0;
		v_we      = 1'b0;
		v_waddr   = x;
		v_wdata   = 8'd0;
		fb_we     = 1'b0;
		fb_clear  = 1'b0;
		stk_we    = 1'b0;
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = font_hit ? FONT[font_off[6:0]] : 8'd0;
			end
			ST_IDLE: begin
				fb_raddr = in_row;
				if (accept && in_mode == MODE_LOAD) begin
					mem_we    = 1'b1;
					mem_waddr = in_addr;
					mem_wdata = in_byte;
				end
			end
			ST_F1: mem_raddr = pc_q + 12'd1;
			ST_RX: v_raddr = y;
			ST_RY: v_raddr = 4'd0;
			ST_EXEC: begin
				case (grp)
					GRP_SYS:  fb_clear = (op_q == OP_CLS);
					GRP_CALL: stk_we = 1'b1;
					GRP_LDI: begin
						v_we = 1'b1; v_wdata = nn;
					end
					GRP_ADDI: begin
						v_we = 1'b1; v_wdata = vx_q + nn;
					end
					GRP_ALU: begin
						v_we = !alu.bad; v_wdata = alu.res;
					end
					GRP_RND: begin
						v_we = 1'b1; v_wdata = rnd_q & nn;
					end
					GRP_MISC: begin
						if (nn == FN_GDLY) begin
							v_we = 1'b1; v_wdata = dnow_q;
						end else if (nn == FN_WKEY) begin
							v_we = (keys_q != 16'd0); v_wdata = {4'd0, low_key};
						end
					end
					default: ;
				endcase
			end
			ST_WRF: begin
				v_we = 1'b1; v_waddr = REG_VF; v_wdata = {7'd0, flag_q};
			end
			ST_DRD: mem_raddr = i_q + {8'd0, r_q};
			ST_DWR: fb_we = 1'b1;
			ST_DEND: begin
				v_we = 1'b1; v_waddr = REG_VF; v_wdata = {7'd0, hit_q};
			end
			ST_B0: begin
				mem_we = 1'b1; mem_wdata = {4'd0, bcd[11:8]};
			end
			ST_B1: begin
				mem_we = 1'b1; mem_waddr = i_q + 12'd1; mem_wdata = {4'd0, bcd[7:4]};
			end
			ST_B2: begin
				mem_we = 1'b1; mem_waddr = i_q + 12'd2; mem_wdata = {4'd0, bcd[3:0]};
			end
			ST_SRD: v_raddr = j_q;
			ST_SWR: begin
				mem_we = 1'b1; mem_waddr = i_q + {8'd0, j_q}; mem_wdata = v_rd;
			end
			ST_LRD: mem_raddr = i_q + {8'd0, j_q};
			ST_LWR: begin
				v_we = 1'b1; v_waddr = j_q; v_wdata = mem_rd_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= 12'd0;
			pc_q    <= PROG_START;
			i_q     <= 12'd0;
			sp_q    <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 12'd1;
					if (clr_q == 12'hFFF) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						if (in_mode == MODE_EXEC) state_q <= ST_F1;
						else if (in_mode == MODE_ROW) state_q <= ST_ROW;
						else state_q <= ST_FIN;
					end
				end
				ST_F1:  state_q <= ST_F2;
				ST_F2:  state_q <= ST_DEC;
				ST_DEC: state_q <= ST_RX;
				ST_RX:  state_q <= ST_RY;
				ST_RY:  state_q <= ST_R0;
				ST_R0:  state_q <= ST_EXEC;
				ST_EXEC: begin
					pc_q <= next_pc;
					case (grp)
						GRP_SYS: begin
							if (op_q == OP_RET) sp_q <= sp_dec;
							state_q <= ST_FIN;
						end
						GRP_CALL: begin
							sp_q    <= sp_inc;
							state_q <= ST_FIN;
						end
						GRP_LDIX: begin
							i_q     <= nnn;
							state_q <= ST_FIN;
						end
						GRP_ALU: state_q <= alu.wr_flag ? ST_WRF : ST_FIN;
						GRP_DRW: state_q <= (n == 4'd0) ? ST_DEND : ST_DRD;
						GRP_MISC: begin
							case (nn)
								FN_ADDI: begin
									i_q     <= i_q + {4'd0, vx_q};
									state_q <= ST_FIN;
								end
								FN_FONT: begin
									i_q     <= FONT_BASE + {2'd0, vx_q, 2'd0} + {4'd0, vx_q};
									state_q <= ST_FIN;
								end
								FN_BCD:  state_q <= ST_B0;
								FN_STOR: state_q <= ST_SRD;
								FN_LOAD: state_q <= ST_LRD;
								default: state_q <= ST_FIN;
							endcase
						end
						default: state_q <= ST_FIN;
					endcase
				end
				ST_WRF: state_q <= ST_FIN;
				ST_DRD: state_q <= ST_DWR;
				ST_DWR: state_q <= ({1'b0, r_q} + 5'd1 == {1'b0, n}) ? ST_DEND : ST_DRD;
				ST_DEND: state_q <= ST_FIN;
				ST_B0: state_q <= ST_B1;
				ST_B1: state_q <= ST_B2;
				ST_B2: state_q <= ST_FIN;
				ST_SRD: state_q <= ST_SWR;
				ST_SWR: state_q <= (j_q == x) ? ST_FIN : ST_SRD;
				ST_LRD: state_q <= ST_LWR;
				ST_LWR: state_q <= (j_q == x) ? ST_FIN : ST_LRD;
				ST_ROW: state_q <= ST_FIN;
				ST_FIN: if (!out_vld_q || m_tready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working and result registers (payload, no reset)
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				keys_q <= s_tdata[40:25];
				rnd_q  <= s_tdata[48:41];
				dnow_q <= s_tdata[56:49];
				row_q  <= 64'd0;
				drew_q <= 1'b0;
				unk_q  <= 1'b0;
				wait_q <= 1'b0;
				dl_q   <= 1'b0;
				sl_q   <= 1'b0;
				tval_q <= 8'd0;
			end
			ST_F1: ophi_q <= mem_rd_q;
			ST_F2: op_q <= {ophi_q, mem_rd_q};
			ST_RX: vx_q <= v_rd;
			ST_RY: vy_q <= v_rd;
			ST_R0: v0_q <= v_rd;
			ST_EXEC: begin
				unk_q  <= unk_now;
				flag_q <= alu.flag;
				r_q    <= 4'd0;
				j_q    <= 4'd0;
				hit_q  <= 1'b0;
				drew_q <= (grp == GRP_DRW) || (op_q == OP_CLS);
				wait_q <= (grp == GRP_MISC) && (nn == FN_WKEY) && (keys_q == 16'd0);
				dl_q   <= (grp == GRP_MISC) && (nn == FN_SDLY);
				sl_q   <= (grp == GRP_MISC) && (nn == FN_SSND);
				if ((grp == GRP_MISC) && (nn == FN_SDLY || nn == FN_SSND)) tval_q <= vx_q;
			end
			ST_DWR: begin
				hit_q <= hit_q | (|(fb_rd & draw_mask));
				r_q   <= r_q + 4'd1;
			end
			ST_SWR, ST_LWR: j_q <= j_q + 4'd1;
			ST_ROW: row_q <= fb_rd;
			default: ;
		endcase
	end

	// output register parts the result from the next transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && (!out_vld_q || m_tready)) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && (!out_vld_q || m_tready))
			out_q <= {7'd0, tval_q, sl_q, dl_q, wait_q, unk_q, drew_q, row_q, pc_q};
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	// a new result only ever comes out of the finishing state
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_FIN))
		else $error("result raised outside finishing state");

	// an accepted transaction always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != ST_IDLE))
		else $error("sequencer stayed idle after accept");

	// a call always moves the stack pointer
	a_call_push: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && grp == GRP_CALL) |=> (sp_q != $past(sp_q)))
		else $error("call did not move the stack pointer");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the instruction core: program loads, execution, row reads
module tb;
	import c8ic_pkg::*;

	typedef struct packed {
		logic [1:0]  mode;
		logic [11:0] load_address;
		logic [7:0]  load_byte;
		logic [4:0]  display_row;
		logic [15:0] keys;
		logic [7:0]  random_value;
		logic [7:0]  delay_now;
	} step_t;

	typedef struct packed {
		logic [11:0] program_counter;
		logic [63:0] row_pixels;
		logic        drew;
		logic        unknown_opcode;
		logic        waiting_for_key;
		logic        delay_load;
		logic        sound_load;
		logic [7:0]  timer_value;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;

	chip8_instruction_core_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// shadow machine state
	logic [7:0]  mem [4096];
	logic [63:0] screen [32];
	logic [7:0]  vreg [16];
	logic [11:0] ireg;
	logic [11:0] pc_q;
	logic [11:0] calls [STACK_DEPTH];
	logic [SP_W-1:0] sp_q;

	step_t    pending_steps[$];
	outcome_t expected_outcomes[$];
	int       errors = 0;
	int       burst_left;
	int       gap_left;
	int       stall_left;
	bit       accepted;
	bit       long_stall_req;
	bit       long_stall_taken;

	function automatic outcome_t execute_step(step_t s);
		outcome_t o;
		logic [11:0] pc, nxt;
		logic [15:0] op;
		logic [3:0] x, y, n;
		logic [7:0] nn, a, b;
		logic [8:0] sum;
		logic hit;
		int px, py;
		o = '0;
		if (s.mode == MODE_LOAD) begin
			mem[s.load_address] = s.load_byte;
		end else if (s.mode == MODE_ROW) begin
			o.row_pixels = screen[s.display_row];
		end else if (s.mode == MODE_EXEC) begin
			pc = pc_q;
			op = {mem[pc], mem[pc + 12'd1]};
			x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0];
			nxt = pc + 12'd2;
			a = vreg[x]; b = vreg[y];
			case (op[15:12])
				GRP_SYS: begin
					if (op == OP_CLS) begin
						for (int r = 0; r < 32; r++) screen[r] = '0;
						o.drew = 1;
					end else if (op == OP_RET) begin
						sp_q = sp_q - 1'b1;
						nxt = calls[sp_q] + 12'd2;
					end else o.unknown_opcode = 1;
				end
				GRP_JP: nxt = op[11:0];
				GRP_CALL: begin
					calls[sp_q] = pc;
					sp_q = sp_q + 1'b1;
					nxt = op[11:0];
				end
				GRP_SEQ:  if (a == nn) nxt = nxt + 12'd2;
				GRP_SNE:  if (a != nn) nxt = nxt + 12'd2;
				GRP_SREQ: if (a == b) nxt = nxt + 12'd2;
				GRP_LDI:  vreg[x] = nn;
				GRP_ADDI: vreg[x] = a + nn;
				GRP_ALU: begin
					case (n)
						ALU_MOV: vreg[x] = b;
						ALU_OR:  vreg[x] = a | b;
						ALU_AND: vreg[x] = a & b;
						ALU_XOR: vreg[x] = a ^ b;
						ALU_ADD: begin
							sum = a + b; vreg[x] = sum[7:0]; vreg[REG_VF] = {7'd0, sum[8]};
						end
						ALU_SUB: begin vreg[x] = a - b; vreg[REG_VF] = {7'd0, a >= b}; end
						ALU_SHR: begin vreg[x] = a >> 1; vreg[REG_VF] = {7'd0, a[0]}; end
						ALU_SBN: begin vreg[x] = b - a; vreg[REG_VF] = {7'd0, b >= a}; end
						ALU_SHL: begin vreg[x] = a << 1; vreg[REG_VF] = {7'd0, a[7]}; end
						default: o.unknown_opcode = 1;
					endcase
				end
				GRP_SRNE: if (a != b) nxt = nxt + 12'd2;
				GRP_LDIX: ireg = op[11:0];
				GRP_JPV:  nxt = op[11:0] + {4'd0, vreg[0]};
				GRP_RND:  vreg[x] = s.random_value & nn;
				GRP_DRW: begin
					// coordinates were latched into a and b before vf changes
					hit = 0;
					for (int r = 0; r < n; r++) begin
						py = (b + r) % 32;
						for (int c = 0; c < 8; c++)
							if (mem[ireg + 12'(r)][7-c]) begin
								px = (a + c) % 64;
								if (screen[py][63-px]) hit = 1;
								screen[py][63-px] = ~screen[py][63-px];
							end
					end
					vreg[REG_VF] = {7'd0, hit};
					o.drew = 1;
				end
				GRP_KEY: begin
					if (nn == KEY_DOWN) begin
						if (s.keys[a[3:0]]) nxt = nxt + 12'd2;
					end else if (nn == KEY_UP) begin
						if (!s.keys[a[3:0]]) nxt = nxt + 12'd2;
					end else o.unknown_opcode = 1;
				end
				default: begin
					case (nn)
						FN_GDLY: vreg[x] = s.delay_now;
						FN_WKEY: begin
							if (s.keys == 0) begin
								o.waiting_for_key = 1; nxt = pc;
							end else begin
								for (int j = 15; j >= 0; j--) if (s.keys[j]) vreg[x] = 8'(j);
							end
						end
						FN_SDLY: begin o.delay_load = 1; o.timer_value = a; end
						FN_SSND: begin o.sound_load = 1; o.timer_value = a; end
						FN_ADDI: ireg = ireg + a;
						FN_FONT: ireg = FONT_BASE + 12'(5 * a);
						FN_BCD: begin
							mem[ireg] = a / 100;
							mem[ireg + 12'd1] = (a / 10) % 10;
							mem[ireg + 12'd2] = a % 10;
						end
						FN_STOR: for (int j = 0; j <= x; j++) mem[ireg + 12'(j)] = vreg[j];
						FN_LOAD: for (int j = 0; j <= x; j++) vreg[j] = mem[ireg + 12'(j)];
						default: o.unknown_opcode = 1;
					endcase
				end
			endcase
			pc_q = nxt;
		end
		o.program_counter = pc_q;
		return o;
	endfunction

	function automatic step_t rand_inputs(logic [1:0] mode);
		step_t s;
		s.mode = mode;
		s.load_address = 12'($urandom);
		s.load_byte = 8'($urandom);
		s.display_row = 5'($urandom);
		s.keys = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
		s.random_value = 8'($urandom);
		s.delay_now = 8'($urandom);
		return s;
	endfunction

	task automatic poke(logic [11:0] addr, logic [7:0] val);
		step_t s;
		s = rand_inputs(MODE_LOAD);
		s.load_address = addr;
		s.load_byte = val;
		pending_steps.push_back(s);
	endtask

	// places an opcode at the given address and runs an execution step
	task automatic run_op(inout logic [11:0] at, input logic [15:0] op);
		poke(at, op[15:8]);
		poke(at + 12'd1, op[7:0]);
		pending_steps.push_back(rand_inputs(MODE_EXEC));
	endtask

	task automatic drain();
		wait (pending_steps.size() == 0 && expected_outcomes.size() == 0);
		@(posedge clk);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("chip8_instruction_core_top test failed");
		$finish;
	end

	// reset and shadow init
	initial begin
		arst_n = 0;
		for (int i = 0; i < 4096; i++) mem[i] = 0;
		for (int i = 0; i < FONT_LEN; i++) mem[FONT_BASE + i] = FONT[i];
		for (int i = 0; i < 32; i++) screen[i] = 0;
		for (int i = 0; i < 16; i++) vreg[i] = 0;
		for (int i = 0; i < STACK_DEPTH; i++) calls[i] = 0;
		ireg = 0; pc_q = PROG_START; sp_q = 0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1;
	end

	// driver: bursts with random gaps, an offered transaction holds until taken
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0; s_tdata <= '0; s_tuser <= MODE_EXEC;
			burst_left <= 0; gap_left <= 0;
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			s_tvalid <= 0;
		end else if (accepted && burst_left <= 1) begin
			s_tvalid <= 0;
			burst_left <= $urandom_range(1, 30);
			gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
		end else if (pending_steps.size() > 0) begin
			if (accepted) burst_left <= burst_left - 1;
			s_tvalid <= 1;
			s_tuser <= pending_steps[0].mode;
			s_tdata <= {7'd0, pending_steps[0].delay_now, pending_steps[0].random_value,
				pending_steps[0].keys, pending_steps[0].display_row,
				pending_steps[0].load_byte, pending_steps[0].load_address};
		end else s_tvalid <= 0;
	end

	// predict on acceptance at the rising edge
	always @(posedge clk) begin
		accepted <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready)
			expected_outcomes.push_back(execute_step(pending_steps.pop_front()));
	end

	// receiver stall pattern
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0; stall_left <= 0; long_stall_taken <= 0;
		end else if (long_stall_req && !long_stall_taken && stall_left == 0) begin
			stall_left <= 3000; m_tready <= 0; long_stall_taken <= 1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1; m_tready <= (stall_left == 1);
		end else begin
			case ($urandom_range(0, 7))
				0: begin stall_left <= $urandom_range(1, 50); m_tready <= 0; end
				1, 2: m_tready <= 0;
				default: m_tready <= 1;
			endcase
		end
	end

	// monitor and field checks
	always @(posedge clk) begin
		outcome_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.program_counter = m_tdata[11:0];
			got.row_pixels      = m_tdata[75:12];
			got.drew            = m_tdata[76];
			got.unknown_opcode  = m_tdata[77];
			got.waiting_for_key = m_tdata[78];
			got.delay_load      = m_tdata[79];
			got.sound_load      = m_tdata[80];
			got.timer_value     = m_tdata[88:81];
			if (expected_outcomes.size() == 0) begin
				$error("result with no expectation: %h", m_tdata);
				errors++;
			end else begin
				want = expected_outcomes.pop_front();
				if (got.program_counter !== want.program_counter) begin
					$error("program_counter exp %h got %h", want.program_counter,
						got.program_counter); errors++; end
				if (got.row_pixels !== want.row_pixels) begin
					$error("row_pixels exp %h got %h", want.row_pixels, got.row_pixels);
					errors++; end
				if (got.drew !== want.drew) begin
					$error("drew exp %b got %b", want.drew, got.drew); errors++; end
				if (got.unknown_opcode !== want.unknown_opcode) begin
					$error("unknown_opcode exp %b got %b", want.unknown_opcode,
						got.unknown_opcode); errors++; end
				if (got.waiting_for_key !== want.waiting_for_key) begin
					$error("waiting_for_key exp %b got %b", want.waiting_for_key,
						got.waiting_for_key); errors++; end
				if (got.delay_load !== want.delay_load) begin
					$error("delay_load exp %b got %b", want.delay_load, got.delay_load);
					errors++; end
				if (got.sound_load !== want.sound_load) begin
					$error("sound_load exp %b got %b", want.sound_load, got.sound_load);
					errors++; end
				if (got.timer_value !== want.timer_value) begin
					$error("timer_value exp %h got %h", want.timer_value,
						got.timer_value); errors++; end
			end
		end
	end

	// stimulus
	initial begin
		logic [11:0] at;
		logic [15:0] op;
		int items;
		step_t s;
		long_stall_req = 0;
		wait (arst_n);
		// directed: field extremes, special cases
		poke(12'hFFF, 8'hFF);
		poke(12'h000, 8'h00);
		s = rand_inputs(MODE_ROW); s.display_row = 5'd31; pending_steps.push_back(s);
		pending_steps.push_back(rand_inputs(MODE_NOP));
		at = 12'h200;
		run_op(at, 16'h6FFF);           // vf = ff
		at = pc_q;
		drain();
		items = 0;
		// random programs: each op placed at the predicted program counter
		while (items < 1400) begin
			at = pc_q;
			case ($urandom_range(0, 9))
				0: op = {GRP_ALU, 8'($urandom), 4'($urandom)};
				1: op = {GRP_DRW, 8'($urandom), 4'($urandom)};
				2: op = {GRP_MISC, 4'($urandom), ($urandom_range(0, 1) ? 8'($urandom) :
					FN_WKEY)};
				3: op = {4'($urandom), 12'($urandom)};
				4: op = ($urandom_range(0, 1)) ? OP_CLS : OP_RET;
				5: op = {GRP_KEY, 4'($urandom), $urandom_range(0, 1) ? KEY_DOWN : KEY_UP};
				6: op = {GRP_MISC, 4'($urandom), ($urandom_range(0, 1) ? FN_STOR : FN_LOAD)};
				7: op = {GRP_MISC, 4'($urandom), ($urandom_range(0, 1) ? FN_BCD : FN_FONT)};
				default: op = {$urandom_range(0, 1) ? GRP_LDI : GRP_ADDI, 12'($urandom)};
			endcase
			// shadow the program bytes now so the next placement sees the new pc
			mem[at] = op[15:8]; mem[at + 12'd1] = op[7:0];
			s = rand_inputs(MODE_LOAD); s.load_address = at; s.load_byte = op[15:8];
			pending_steps.push_back(s);
			s.load_address = at + 12'd1; s.load_byte = op[7:0];
			pending_steps.push_back(s);
			s = rand_inputs(MODE_EXEC);
			pending_steps.push_back(s);
			items += 3;
			if ($urandom_range(0, 4) == 0) begin
				pending_steps.push_back(rand_inputs(MODE_ROW));
				items++;
			end
			if ($urandom_range(0, 20) == 0) begin
				pending_steps.push_back(rand_inputs(MODE_LOAD));
				items++;
			end
			if (items >= 600) long_stall_req = 1;
			// wait for the prediction so pc_q is current
			drain();
		end
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("chip8_instruction_core_top test passed");
		end else begin
			$display("chip8_instruction_core_top test failed");
		end
		$finish;
	end
endmodule
